@@ hw/rtl/lcd_pkg.sv @@
// lcd_pkg: shared types, codes and helpers for the lasso coordinate descent block
// no dependencies
`timescale 1ns / 1ps

package lcd_pkg;

    // operation codes carried on s_tuser
    localparam logic [1:0] OP_LOAD_FEATURE = 2'd0;
    localparam logic [1:0] OP_LOAD_TARGET  = 2'd1;
    localparam logic [1:0] OP_RUN          = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LAMBDA       = 2'd0;
    localparam logic [1:0] CFG_NUM_ITER     = 2'd1;
    localparam logic [1:0] CFG_NUM_SAMPLES  = 2'd2;
    localparam logic [1:0] CFG_NUM_FEATURES = 2'd3;

    // register reset values
    localparam logic [30:0] LAMBDA_RST       = 31'd655;
    localparam logic [15:0] NUM_ITER_RST     = 16'd100;
    localparam logic [10:0] NUM_SAMPLES_RST  = 11'd1024;
    localparam logic [5:0]  NUM_FEATURES_RST = 6'd32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ACC,
        ST_ACC_DRAIN,
        ST_DIV,
        ST_DIV_WAIT,
        ST_COMBINE,
        ST_THRESH,
        ST_WRITE,
        ST_UPD,
        ST_UPD_DRAIN,
        ST_NEXT,
        ST_EMIT
    } lcd_state_t;

    // clamp a signed value into 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/lcd_ram.sv @@
// lcd_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module lcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/lcd_div.sv @@
// lcd_div: restoring unsigned divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps

module lcd_div #(
    parameter int DW = 58,
    parameter int VW = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CNTW = $clog2(DW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [VW-1:0]   rem_reg;
    logic [DW-1:0]   quo_reg;

    logic [VW:0]     trial;
    logic [VW:0]     diff;
    logic            ge;
    logic [VW-1:0]   rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[DW-1]};
        diff     = trial - {1'b0, divisor};
        ge       = trial >= {1'b0, divisor};
        rem_next = ge ? diff[VW-1:0] : trial[VW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hw/rtl/lasso_coordinate_descent_top.sv @@
// lasso_coordinate_descent_top: lasso fit by cyclic coordinate descent, fixed point
// depends on lcd_pkg, lcd_ram, lcd_div
`timescale 1ns / 1ps

// Loads are taken while idle: a feature word writes the feature RAM (feature-major,
// MAX_SAMPLES entries per feature), a target word seeds the residual RAM. A run
// word clears the coefficients and repeats the configured number of sweeps over the
// features in use. Each coordinate streams the feature column and the residuals
// through a read-multiply-accumulate pipeline at one sample per cycle, drains it,
// divides the sum by n in a bit-serial divider, adds the old value, soft-thresholds
// and stores the result, and, when the value changed, streams the residuals once
// more through the same pipeline with write-back before stepping on. After the last
// sweep the coefficients leave one word per cycle while the receiver is ready, with
// tlast on the final one. The block takes no word while a run is in progress;
// configuration is to be written while idle, which the block itself does not enforce.

module lasso_coordinate_descent_top
    import lcd_pkg::*;
#(
    parameter int MAX_SAMPLES  = 1024,
    parameter int MAX_FEATURES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_index[9:0], feature_index[14:10], value[30:15]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    // coefficient words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // coef_index[4:0], coef_value[36:5]
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [30:0] cfg_wdata
);

    localparam int SAW    = $clog2(MAX_SAMPLES);
    localparam int FAW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int NCW    = $clog2(MAX_SAMPLES + 1);
    localparam int FCW    = $clog2(MAX_FEATURES + 1);
    localparam int FDEPTH = MAX_SAMPLES * MAX_FEATURES;
    localparam int FADW   = $clog2(FDEPTH);
    localparam int SUM_W  = 48 + SAW;     // sum of 48-bit products over n samples
    localparam int QW     = SUM_W - 12;   // quotient after dropping the Q.12 scale
    localparam int CW     = SUM_W - 8;    // coefficient candidate width with headroom

    // configuration registers
    logic [30:0] lambda_reg;
    logic [15:0] num_iter_reg;
    logic [10:0] num_samples_reg;
    logic [5:0]  num_features_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lambda_reg       <= LAMBDA_RST;
            num_iter_reg     <= NUM_ITER_RST;
            num_samples_reg  <= NUM_SAMPLES_RST;
            num_features_reg <= NUM_FEATURES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_LAMBDA:       lambda_reg       <= cfg_wdata;
                CFG_NUM_ITER:     num_iter_reg     <= cfg_wdata[15:0];
                CFG_NUM_SAMPLES:  num_samples_reg  <= cfg_wdata[10:0];
                CFG_NUM_FEATURES: num_features_reg <= cfg_wdata[5:0];
            endcase
        end
    end

    // input word fields
    logic [1:0]         in_op;
    logic [9:0]         in_sample;
    logic [4:0]         in_feature;
    logic signed [15:0] in_value;
    logic               s_acc;

    assign in_op      = s_tuser;
    assign in_sample  = s_tdata[9:0];
    assign in_feature = s_tdata[14:10];
    assign in_value   = s_tdata[30:15];
    assign s_acc      = s_tvalid && s_tready;

    // state and counters
    lcd_state_t state_reg, state_next;

    logic [SAW-1:0]  i_reg;
    logic [FAW-1:0]  k_reg;
    logic [15:0]     it_reg;
    logic [FADW-1:0] base_reg;
    logic [NCW-1:0]  n_reg;
    logic [FCW-1:0]  nf_reg;
    logic            mode_reg;     // 1 while the residual update pass runs

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [CW-1:0]    c_reg;
    logic signed [31:0]      nw_reg;
    logic signed [32:0]      delta_reg;
    logic signed [31:0]      coef_reg [MAX_FEATURES];

    // pipeline of the streaming pass
    logic                 v1_reg, v2_reg, v3_reg;
    logic [SAW-1:0]       i1_reg, i2_reg, i3_reg;
    logic signed [31:0]   r2_reg, r3_reg;
    logic signed [48:0]   prod_reg;
    logic signed [36:0]   t3_reg;

    // output register
    logic               m_valid_reg;
    logic [4:0]         m_index_reg;
    logic signed [31:0] m_value_reg;
    logic               m_last_reg;

    // clamped sizes for a new run
    logic [31:0] ns32, nf32, n_clamp, nf_clamp;

    always_comb begin
        ns32 = 32'(num_samples_reg);
        nf32 = 32'(num_features_reg);
        if (ns32 == 32'd0) begin
            n_clamp = 32'd1;
        end else if (ns32 > 32'(MAX_SAMPLES)) begin
            n_clamp = 32'(MAX_SAMPLES);
        end else begin
            n_clamp = ns32;
        end
        if (nf32 == 32'd0) begin
            nf_clamp = 32'd1;
        end else if (nf32 > 32'(MAX_FEATURES)) begin
            nf_clamp = 32'(MAX_FEATURES);
        end else begin
            nf_clamp = nf32;
        end
    end

    // status used by both the next state and the datapath
    logic               last_i, last_k, last_it, pipe_busy, changed;
    logic signed [31:0] old_coef;

    assign old_coef  = coef_reg[k_reg];
    assign last_i    = (NCW'(i_reg) + NCW'(1)) == n_reg;
    assign last_k    = (FCW'(k_reg) + FCW'(1)) == nf_reg;
    assign last_it   = (17'(it_reg) + 17'd1) == 17'(num_iter_reg);
    assign pipe_busy = v1_reg || v2_reg || v3_reg;
    assign changed   = nw_reg != old_coef;

    // divider hookup
    logic                 div_start, div_done;
    logic [SUM_W-1:0]     sum_mag, quo;
    logic                 sum_neg;

    assign sum_neg = sum_reg[SUM_W-1];
    assign sum_mag = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    lcd_div #(
        .DW(SUM_W),
        .VW(NCW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_acc && in_op == OP_RUN) state_next = ST_INIT;
            ST_INIT:      state_next = (num_iter_reg == 16'd0) ? ST_EMIT : ST_ACC;
            ST_ACC:       if (last_i) state_next = ST_ACC_DRAIN;
            ST_ACC_DRAIN: if (!pipe_busy) state_next = ST_DIV;
            ST_DIV:       state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (div_done) state_next = ST_COMBINE;
            ST_COMBINE:   state_next = ST_THRESH;
            ST_THRESH:    state_next = ST_WRITE;
            ST_WRITE:     state_next = changed ? ST_UPD : ST_NEXT;
            ST_UPD:       if (last_i) state_next = ST_UPD_DRAIN;
            ST_UPD_DRAIN: if (!pipe_busy) state_next = ST_NEXT;
            ST_NEXT:      state_next = (last_k && last_it) ? ST_EMIT : ST_ACC;
            ST_EMIT: begin
                if ((!m_valid_reg || m_tready) && last_k) state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // state outputs
    logic issue, emit_load, run_init;

    always_comb begin
        issue     = 1'b0;
        emit_load = 1'b0;
        run_init  = 1'b0;
        div_start = 1'b0;
        s_tready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:        s_tready  = 1'b1;
            ST_INIT:        run_init  = 1'b1;
            ST_ACC, ST_UPD: issue     = 1'b1;
            ST_DIV:         div_start = 1'b1;
            ST_EMIT:        emit_load = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // load side: feature and target writes
    logic            feat_we, tgt_we;
    logic [FADW-1:0] feat_waddr, feat_raddr;

    assign feat_we = s_acc && in_op == OP_LOAD_FEATURE
                     && 32'(in_sample) < 32'(MAX_SAMPLES)
                     && 32'(in_feature) < 32'(MAX_FEATURES);
    assign tgt_we  = s_acc && in_op == OP_LOAD_TARGET
                     && 32'(in_sample) < 32'(MAX_SAMPLES);
    assign feat_waddr = FADW'(in_feature) * FADW'(MAX_SAMPLES) + FADW'(in_sample);
    assign feat_raddr = base_reg + FADW'(i_reg);

    // residual write-back from the last pipeline stage of the update pass, shared with target loads
    logic signed [31:0] res_new;
    logic               res_we;
    logic [SAW-1:0]     res_waddr;
    logic [31:0]        res_wdata;

    assign res_new   = sat32(64'(r3_reg) + 64'(t3_reg));
    assign res_we    = tgt_we || (v3_reg && mode_reg);
    assign res_waddr = tgt_we ? SAW'(in_sample) : i3_reg;
    assign res_wdata = tgt_we ? {{12{in_value[15]}}, in_value, 4'b0000} : res_new;

    logic signed [15:0] x_rd;
    logic signed [31:0] r_rd;

    lcd_ram #(
        .WIDTH(16),
        .DEPTH(FDEPTH)
    ) u_feature_ram (
        .aclk  (aclk),
        .we    (feat_we),
        .waddr (feat_waddr),
        .wdata (in_value),
        .raddr (feat_raddr),
        .rdata (x_rd)
    );

    lcd_ram #(
        .WIDTH(32),
        .DEPTH(MAX_SAMPLES)
    ) u_residual_ram (
        .aclk  (aclk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .raddr (i_reg),
        .rdata (r_rd)
    );

    // one shared multiplier: r*x while accumulating, x*delta while updating
    logic signed [32:0] mul_a;
    logic signed [48:0] prod_next;
    logic signed [48:0] prod_bias;
    logic signed [36:0] t3_next;

    assign mul_a     = mode_reg ? delta_reg : 33'(r_rd);
    assign prod_next = mul_a * x_rd;
    // divide by 4096 rounding toward zero
    assign prod_bias = prod_reg + (prod_reg[48] ? 49'sd4095 : 49'sd0);
    assign t3_next   = prod_bias[48:12];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        i1_reg   <= i_reg;
        i2_reg   <= i1_reg;
        r2_reg   <= r_rd;
        prod_reg <= prod_next;
        i3_reg   <= i2_reg;
        r3_reg   <= r2_reg;
        t3_reg   <= t3_next;
    end

    // coefficient candidate and soft threshold
    logic [QW-1:0]        q_mag;
    logic signed [CW-1:0] q_s, lam_c, tm, tp, sel;

    always_comb begin
        q_mag = quo[SUM_W-1:12];
        q_s   = sum_neg ? -CW'(q_mag) : CW'(q_mag);
        lam_c = CW'(lambda_reg);
        tm    = c_reg - lam_c;
        tp    = c_reg + lam_c;
        if (tm > 0) begin
            sel = tm;
        end else if (tp < 0) begin
            sel = tp;
        end else begin
            sel = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_COMBINE) begin
            c_reg <= q_s + CW'(old_coef);
        end
        if (state_reg == ST_THRESH) begin
            nw_reg <= sat32(64'(sel));
        end
        if (state_reg == ST_WRITE) begin
            delta_reg <= 33'(old_coef) - 33'(nw_reg);
        end
    end

    // control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg    <= '0;
            k_reg    <= '0;
            it_reg   <= '0;
            base_reg <= '0;
            mode_reg <= 1'b0;
            n_reg    <= NCW'(1);
            nf_reg   <= FCW'(1);
        end else begin
            if (run_init) begin
                i_reg    <= '0;
                k_reg    <= '0;
                it_reg   <= '0;
                base_reg <= '0;
                mode_reg <= 1'b0;
                n_reg    <= NCW'(n_clamp);
                nf_reg   <= FCW'(nf_clamp);
            end
            if (issue) begin
                i_reg <= last_i ? '0 : i_reg + SAW'(1);
            end
            if (state_reg == ST_WRITE) begin
                mode_reg <= changed;
            end
            if (state_reg == ST_NEXT) begin
                mode_reg <= 1'b0;
                if (last_k) begin
                    k_reg    <= '0;
                    base_reg <= '0;
                    if (!last_it) begin
                        it_reg <= it_reg + 16'd1;
                    end
                end else begin
                    k_reg    <= k_reg + FAW'(1);
                    base_reg <= base_reg + FADW'(MAX_SAMPLES);
                end
            end
            if (emit_load) begin
                k_reg <= k_reg + FAW'(1);
            end
        end
    end

    // accumulator, cleared before each coordinate
    always_ff @(posedge aclk) begin
        if (run_init || state_reg == ST_NEXT) begin
            sum_reg <= '0;
        end else if (v2_reg && !mode_reg) begin
            sum_reg <= sum_reg + SUM_W'(prod_reg);
        end
    end

    // coefficient store, cleared at the start of a run
    always_ff @(posedge aclk) begin
        if (!aresetn || run_init) begin
            for (int j = 0; j < MAX_FEATURES; j++) begin
                coef_reg[j] <= '0;
            end
        end else if (state_reg == ST_WRITE) begin
            coef_reg[k_reg] <= nw_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_index_reg <= 5'(k_reg);
            m_value_reg <= old_coef;
            m_last_reg  <= last_k;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_value_reg, m_index_reg};
    assign m_tlast  = m_last_reg;

endmodule

@@ sim/lcd_checker.sv @@
// lcd_checker: watches the word, coefficient and configuration ports of the lasso block,
// predicts every coefficient and compares; depends on lcd_pkg
`timescale 1ns / 1ps

module lcd_checker
    import lcd_pkg::*;
#(
    parameter int MAX_SAMPLES  = 1024,
    parameter int MAX_FEATURES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [30:0] cfg_wdata,
    output int          errors,
    output int          pending,
    output int          fits_seen,
    output int          coefs_seen
);

    typedef struct {
        logic [4:0]         idx;
        logic signed [31:0] val;
        logic               last;
    } coef_word_t;

    shortint    x_mem [MAX_FEATURES][MAX_SAMPLES];
    int         resid [MAX_SAMPLES];
    int         coef [MAX_FEATURES];
    coef_word_t coef_q [$];

    logic [30:0] lam_r;
    logic [15:0] iter_r;
    logic [10:0] nsamp_r;
    logic [5:0]  nfeat_r;

    function automatic int clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return -32'sh8000_0000;
        return int'(v);
    endfunction

    // one full fit with the current registers, expected words queued in order
    task automatic fit_coefs();
        int         n;
        int         nf;
        int         nw;
        longint     sum;
        longint     c;
        longint     old;
        longint     delta;
        longint     lam;
        coef_word_t w;
        n   = (nsamp_r == 0) ? 1 : (nsamp_r > MAX_SAMPLES) ? MAX_SAMPLES : int'(nsamp_r);
        nf  = (nfeat_r == 0) ? 1 : (nfeat_r > MAX_FEATURES) ? MAX_FEATURES : int'(nfeat_r);
        lam = longint'(lam_r);
        foreach (coef[k]) coef[k] = 0;
        for (int it = 0; it < int'(iter_r); it++) begin
            for (int k = 0; k < nf; k++) begin
                old = coef[k];
                sum = 0;
                for (int i = 0; i < n; i++) sum += longint'(resid[i]) * longint'(x_mem[k][i]);
                c = sum / (longint'(n) * 4096) + old;
                if (c - lam > 0) c = c - lam;
                else if (c + lam < 0) c = c + lam;
                else c = 0;
                nw = clamp32(c);
                if (longint'(nw) != old) begin
                    delta = old - longint'(nw);
                    for (int i = 0; i < n; i++)
                        resid[i] = clamp32(longint'(resid[i]) +
                                           (longint'(x_mem[k][i]) * delta) / 4096);
                end
                coef[k] = nw;
            end
        end
        for (int k = 0; k < nf; k++) begin
            w.idx  = k[4:0];
            w.val  = coef[k];
            w.last = (k == nf - 1);
            coef_q.push_back(w);
        end
    endtask

    always @(posedge aclk) begin
        coef_word_t  e;
        logic [9:0]  s_idx;
        logic [4:0]  f_idx;
        logic [15:0] v;
        if (!aresetn) begin
            lam_r   = LAMBDA_RST;
            iter_r  = NUM_ITER_RST;
            nsamp_r = NUM_SAMPLES_RST;
            nfeat_r = NUM_FEATURES_RST;
            coef_q.delete();
            errors     = 0;
            fits_seen  = 0;
            coefs_seen = 0;
        end else begin
            // outgoing word first: it belongs to an earlier run
            if (m_tvalid && m_tready) begin
                coefs_seen++;
                if (coef_q.size() == 0) begin
                    errors++;
                    $display("%0t: coefficient word with none expected: idx %0d val %0d",
                             $time, m_tdata[4:0], $signed(m_tdata[36:5]));
                end else begin
                    e = coef_q.pop_front();
                    if (m_tdata[4:0] !== e.idx) begin
                        errors++;
                        $display("%0t: coef index expected %0d actual %0d",
                                 $time, e.idx, m_tdata[4:0]);
                    end
                    if (m_tdata[36:5] !== e.val) begin
                        errors++;
                        $display("%0t: coef %0d value expected %0d actual %0d",
                                 $time, e.idx, e.val, $signed(m_tdata[36:5]));
                    end
                    if (m_tlast !== e.last) begin
                        errors++;
                        $display("%0t: coef %0d tlast expected %0b actual %0b",
                                 $time, e.idx, e.last, m_tlast);
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_LAMBDA:       lam_r   = cfg_wdata;
                    CFG_NUM_ITER:     iter_r  = cfg_wdata[15:0];
                    CFG_NUM_SAMPLES:  nsamp_r = cfg_wdata[10:0];
                    CFG_NUM_FEATURES: nfeat_r = cfg_wdata[5:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                s_idx = s_tdata[9:0];
                f_idx = s_tdata[14:10];
                v     = s_tdata[30:15];
                case (s_tuser)
                    OP_LOAD_FEATURE: x_mem[f_idx][s_idx] = shortint'(v);
                    OP_LOAD_TARGET:  resid[s_idx] = int'(shortint'(v)) * 16;
                    OP_RUN: begin
                        fits_seen++;
                        fit_coefs();
                    end
                    default: ;
                endcase
            end
        end
        pending = coef_q.size();
    end

endmodule

@@ sim/tb.sv @@
// tb: stimulus and verdict for lasso_coordinate_descent_top
// depends on lcd_pkg, the block and lcd_checker
`timescale 1ns / 1ps

module tb
    import lcd_pkg::*;
();

    localparam int MAXS  = 1024;
    localparam int MAXF  = 32;
    localparam int LIMIT = 3000000;   // cycles, far above the slowest correct run

    // operation code with no meaning, must be ignored by the block
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;    // sample_index[9:0], feature_index[14:10], value[30:15]
    logic [1:0]  s_tuser = '0;    // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // coef_index[4:0], coef_value[36:5]
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [30:0] cfg_wdata = '0;

    int errors, pending, fits_seen, coefs_seen;
    int cycles = 0;
    int words_sent = 0;

    // knobs shared with the receiver
    bit calm = 0;         // no idling at all, used in the last stretch
    bit pressure = 0;     // ask the receiver for one long hold-off
    bit held = 0;
    int hold_left = 0;
    int rx_gap = 0;

    // effective sizes and which store entries hold data
    int n_eff = 1;
    int nf_eff = 1;
    bit x_loaded [MAXF][MAXS];
    bit r_loaded [MAXS];

    lasso_coordinate_descent_top #(.MAX_SAMPLES(MAXS), .MAX_FEATURES(MAXF)) uut (.*);

    lcd_checker #(.MAX_SAMPLES(MAXS), .MAX_FEATURES(MAXF)) u_check (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (pressure && !held && m_tvalid) begin
            held = 1;
            hold_left = 300;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(1, 7) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // small values most of the time so the fit stays in range, full range now and then
    function automatic logic [15:0] pick_value();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 8192)) - 4096);
    endfunction

    // offer one word, leave tvalid high once it is taken
    task automatic send_word(input logic [1:0] op, input logic [9:0] s,
                             input logic [4:0] f, input logic [15:0] v);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, v, f, s};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (op == OP_LOAD_FEATURE) x_loaded[f][s] = 1;
        if (op == OP_LOAD_TARGET) r_loaded[s] = 1;
    endtask

    // drop tvalid, wait for every coefficient, then let the block drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [30:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [30:0] lam, input logic [15:0] iters,
                             input logic [10:0] ns, input logic [5:0] nf);
        write_reg(CFG_LAMBDA, lam);
        write_reg(CFG_NUM_ITER, 31'(iters));
        write_reg(CFG_NUM_SAMPLES, 31'(ns));
        write_reg(CFG_NUM_FEATURES, 31'(nf));
        n_eff  = (ns == 0) ? 1 : (ns > MAXS) ? MAXS : int'(ns);
        nf_eff = (nf == 0) ? 1 : (nf > MAXF) ? MAXF : int'(nf);
    endtask

    // a run reads every entry in use, so load whatever is still empty, then run
    task automatic run_fit();
        for (int k = 0; k < nf_eff; k++)
            for (int i = 0; i < n_eff; i++)
                if (!x_loaded[k][i]) send_word(OP_LOAD_FEATURE, i[9:0], k[4:0], pick_value());
        for (int i = 0; i < n_eff; i++)
            if (!r_loaded[i]) send_word(OP_LOAD_TARGET, i[9:0], 5'($urandom), pick_value());
        send_word(OP_RUN, 10'($urandom), 5'($urandom), 16'($urandom));
    endtask

    initial begin
        int nwords;
        int sel;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extreme values and indexes, a plain fit and a repeat without reseeding
        configure(31'd0, 16'd1, 11'd2, 6'd2);
        send_word(OP_LOAD_FEATURE, 10'd0, 5'd0, 16'h7FFF);
        send_word(OP_LOAD_FEATURE, 10'd1, 5'd0, 16'h8000);
        send_word(OP_LOAD_FEATURE, 10'd0, 5'd1, 16'h1000);
        send_word(OP_LOAD_FEATURE, 10'd1, 5'd1, 16'hF000);
        send_word(OP_LOAD_TARGET, 10'd0, 5'd0, 16'h7FFF);
        send_word(OP_LOAD_TARGET, 10'd1, 5'd31, 16'h8000);
        send_word(OP_LOAD_FEATURE, 10'd1023, 5'd31, 16'hFFFF);
        send_word(OP_LOAD_TARGET, 10'd1023, 5'd0, 16'h0000);
        send_word(OP_UNUSED, 10'h3FF, 5'h1F, 16'hFFFF);    // ignored by the block
        run_fit();
        run_fit();
        settle();
        // zero sweeps give all-zero coefficients
        configure(31'd0, 16'd0, 11'd2, 6'd2);
        run_fit();
        settle();
        // huge threshold zeroes everything
        configure(31'h7FFF_FFFF, 16'd3, 11'd2, 6'd2);
        run_fit();
        settle();
        // zero sizes act as one; iteration register takes every bit once
        write_reg(CFG_NUM_ITER, 31'h0000_FFFF);
        configure(31'd1000, 16'd4, 11'd0, 6'd0);
        run_fit();
        settle();
        // features above the maximum act as all of them; receiver holds off meanwhile
        configure(31'd5, 16'd2, 11'd1, 6'd63);
        pressure = 1;
        run_fit();
        for (int j = 0; j < 4; j++)
            send_word(OP_LOAD_TARGET, 10'($urandom_range(0, 3)), 5'd0, pick_value());
        settle();
        pressure = 0;
        // long sweep count on one feature
        configure(31'd100, 16'd1000, 11'd1, 6'd1);
        run_fit();
        settle();

        // random phases: loads mostly inside the sizes in use, some noise, then a run
        configure(31'($urandom_range(0, 4096)), 16'($urandom_range(1, 8)),
                  11'($urandom_range(1, 4)), 6'($urandom_range(1, 3)));
        while (words_sent < 160) begin
            if (words_sent > 130) calm = 1;
            if ($urandom_range(0, 2) == 0) begin
                settle();
                sel = $urandom_range(0, 9);
                configure(sel == 0 ? 31'd0 : sel == 1 ? 31'h7FFF_FFFF :
                          31'($urandom_range(0, 131072)),
                          16'($urandom_range(1, 12)),
                          sel == 2 ? 11'($urandom_range(5, 8)) :
                          sel == 3 ? 11'd1 : 11'($urandom_range(1, 4)),
                          sel == 3 ? 6'd32 : 6'($urandom_range(1, 3)));
            end
            nwords = $urandom_range(3, 10);
            for (int j = 0; j < nwords; j++) begin
                sel = $urandom_range(0, 15);
                if (sel == 0)
                    send_word(OP_UNUSED, 10'($urandom), 5'($urandom), 16'($urandom));
                else if (sel == 1)
                    send_word(OP_LOAD_FEATURE, 10'($urandom), 5'($urandom), pick_value());
                else if (sel < 9)
                    send_word(OP_LOAD_FEATURE, 10'($urandom_range(0, n_eff - 1)),
                              5'($urandom_range(0, nf_eff - 1)), pick_value());
                else
                    send_word(OP_LOAD_TARGET, 10'($urandom_range(0, n_eff - 1)),
                              5'($urandom), pick_value());
            end
            run_fit();
        end
        settle();

        $display("%0d words sent, %0d fits run, %0d coefficients compared",
                 words_sent, fits_seen, coefs_seen);
        $display("covered sign extremes, zero and clamped sizes, threshold extremes, stalls");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/lcd_pkg.sv
hw/rtl/lcd_ram.sv
hw/rtl/lcd_div.sv
hw/rtl/lasso_coordinate_descent_top.sv
sim/lcd_checker.sv
sim/tb.sv
